[src/tme_pkg.sv]
// shared types, constants and opcodes for the tape machine instruction executor
// no dependencies; imported by the tape, issue, execute and top modules
`default_nettype none

package tme_pkg;

  localparam int TAPE_CELLS = 32768;
  localparam int PTR_W      = $clog2(TAPE_CELLS);
  localparam int ARG_W      = 16;
  localparam int SUM_W      = ((PTR_W > ARG_W) ? PTR_W : ARG_W) + 1;
  localparam int LOC_W      = 16;
  localparam int CELL_W     = 8;
  localparam int OP_W       = 3;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [ARG_W-1:0]  arg_t;
  typedef logic [LOC_W-1:0]  loc_t;

  localparam op_t OP_ADD = 3'd0;
  localparam op_t OP_SUB = 3'd1;
  localparam op_t OP_SHL = 3'd2;
  localparam op_t OP_SHR = 3'd3;
  localparam op_t OP_OUT = 3'd4;
  localparam op_t OP_IN  = 3'd5;
  localparam op_t OP_JZ  = 3'd6;
  localparam op_t OP_JNZ = 3'd7;

  // instruction held in the execute stage while its cell read completes
  typedef struct packed {
    op_t   op;
    arg_t  arg;
    cell_t byte_in;
    ptr_t  addr;
    logic  err;
    logic  fwd;
    cell_t fwd_data;
  } issue_t;

  typedef struct packed {
    logic  en;
    ptr_t  addr;
    cell_t data;
  } tape_wr_t;

  typedef struct packed {
    loc_t  next_loc;
    logic  emit;
    cell_t byte_o;
    arg_t  repeat_o;
    logic  err;
  } result_t;

endpackage

`default_nettype wire

[src/tme_tape.sv]
// tape memory: one write port, one registered read port, clearing sweep after reset
// depends on tme_pkg
`default_nettype none

module tme_tape (
  input  logic            clk,
  input  logic            rst_n,
  input  tme_pkg::tape_wr_t wr,
  input  logic            rd_en,
  input  tme_pkg::ptr_t   rd_addr,
  output tme_pkg::cell_t  rd_data,
  output logic            clr_busy
);
  import tme_pkg::*;

  cell_t mem [TAPE_CELLS];
  cell_t rd_data_r;
  logic  clr_busy_r;
  ptr_t  clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + ptr_t'(1);
      if (clr_cnt_r == ptr_t'(TAPE_CELLS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

`default_nettype wire

[src/tme_issue.sv]
// issue stage: input transfer, pointer moves, bound check, halt flag, cell read
// depends on tme_pkg; feeds tme_exec and reads tme_tape
`default_nettype none

module tme_issue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,
  input  tme_pkg::op_t      in_tuser,
  input  logic              clr_busy,
  input  logic              s1_go,
  input  tme_pkg::tape_wr_t wr,
  output logic              rd_en,
  output tme_pkg::ptr_t     rd_addr,
  output logic              s1_v,
  output tme_pkg::issue_t   s1
);
  import tme_pkg::*;

  logic   accept;
  arg_t   arg;
  cell_t  byte_in;
  logic [SUM_W-1:0] ptr_ext;
  logic [SUM_W-1:0] arg_ext;
  logic [SUM_W-1:0] rgt_sum;
  logic [SUM_W-1:0] lft_dif;
  logic   bad;
  logic   err;

  ptr_t   ptr_r, ptr_nxt;
  logic   halted_r, halted_nxt;
  logic   s1_v_r, s1_v_nxt;
  issue_t s1_r;

  assign arg     = in_tdata[15:0];
  assign byte_in = in_tdata[23:16];

  assign in_tready = !clr_busy && (!s1_v_r || s1_go);
  assign accept    = in_tvalid && in_tready;

  assign ptr_ext = SUM_W'(ptr_r);
  assign arg_ext = SUM_W'(arg);
  assign rgt_sum = ptr_ext + arg_ext;
  assign lft_dif = ptr_ext - arg_ext;

  always_comb begin
    bad = 1'b0;
    if (in_tuser == OP_SHL) begin
      bad = arg_ext > ptr_ext;
    end else if (in_tuser == OP_SHR) begin
      bad = rgt_sum > SUM_W'(TAPE_CELLS - 1);
    end
  end

  assign err = halted_r || bad;

  always_comb begin
    ptr_nxt    = ptr_r;
    halted_nxt = halted_r;
    if (accept) begin
      halted_nxt = halted_r || bad;
      if (!err && in_tuser == OP_SHL) begin
        ptr_nxt = lft_dif[PTR_W-1:0];
      end else if (!err && in_tuser == OP_SHR) begin
        ptr_nxt = rgt_sum[PTR_W-1:0];
      end
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      halted_r <= 1'b0;
      s1_v_r   <= 1'b0;
    end else begin
      ptr_r    <= ptr_nxt;
      halted_r <= halted_nxt;
      s1_v_r   <= s1_v_nxt;
    end
  end

  // a write landing in the same cycle as the read is missed by the memory
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.op       <= in_tuser;
      s1_r.arg      <= arg;
      s1_r.byte_in  <= byte_in;
      s1_r.addr     <= ptr_r;
      s1_r.err      <= err;
      s1_r.fwd      <= wr.en && (wr.addr == ptr_r);
      s1_r.fwd_data <= wr.data;
    end
  end

  assign rd_en   = accept;
  assign rd_addr = ptr_r;
  assign s1_v    = s1_v_r;
  assign s1      = s1_r;

endmodule

`default_nettype wire

[src/tme_exec.sv]
// execute stage: cell update, write-back, next location and result register
// depends on tme_pkg; takes the issue stage and the tape read data
`default_nettype none

module tme_exec (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_v,
  input  tme_pkg::issue_t   s1,
  input  tme_pkg::cell_t    rd_data,
  output logic              s1_go,
  output tme_pkg::tape_wr_t wr,
  output logic              out_tvalid,
  input  logic              out_tready,
  output tme_pkg::result_t  res
);
  import tme_pkg::*;

  cell_t   cur_cell;
  logic    we;
  cell_t   wdata;
  result_t res_c;
  loc_t    loc_r, loc_nxt;
  logic    out_v_r, out_v_nxt;
  result_t res_r;

  assign cur_cell = s1.fwd ? s1.fwd_data : rd_data;
  assign s1_go    = s1_v && (!out_v_r || out_tready);

  always_comb begin
    we       = 1'b0;
    wdata    = cur_cell;
    res_c    = '0;
    res_c.next_loc = loc_r + loc_t'(1);
    unique case (s1.op)
      OP_ADD: begin
        we    = 1'b1;
        wdata = cur_cell + s1.arg[CELL_W-1:0];
      end
      OP_SUB: begin
        we    = 1'b1;
        wdata = cur_cell - s1.arg[CELL_W-1:0];
      end
      OP_SHL, OP_SHR: begin
        we = 1'b0;
      end
      OP_OUT: begin
        if (s1.arg != '0) begin
          res_c.emit     = 1'b1;
          res_c.byte_o   = cur_cell;
          res_c.repeat_o = s1.arg;
        end
      end
      OP_IN: begin
        we    = s1.arg != '0;
        wdata = s1.byte_in;
      end
      OP_JZ: begin
        if (cur_cell == '0) begin
          res_c.next_loc = s1.arg;
        end
      end
      OP_JNZ: begin
        if (cur_cell != '0) begin
          res_c.next_loc = s1.arg;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
    // halted or out of bounds: location holds, no write and no output; the error flag is set
    if (s1.err) begin
      we    = 1'b0;
      res_c = '0;
      res_c.next_loc = loc_r;
      res_c.err      = 1'b1;
    end
  end

  assign wr.en   = s1_go && we;
  assign wr.addr = s1.addr;
  assign wr.data = wdata;

  assign loc_nxt   = s1_go ? res_c.next_loc : loc_r;
  assign out_v_nxt = s1_go ? 1'b1 : (out_tready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      loc_r   <= loc_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      res_r <= res_c;
    end
  end

  assign out_tvalid = out_v_r;
  assign res        = res_r;

endmodule

`default_nettype wire

[src/tape_machine_instruction_executor_top.sv]
// path: input transfer -> issue register and tape read -> execute stage result register
// throughput: one instruction per cycle unless the output stalls; same-cell back-to-back
// access is forwarded; the tape read port and the single write-back port set that rate
// reset: pointer, location and halt flag clear at once; the tape is then zeroed by a
// sweep over all TAPE_CELLS (32768) cells during which in_tready stays low
`default_nettype none

module tape_machine_instruction_executor_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // operand[15:0], in_byte[23:16]
  input  logic [2:0]  in_tuser,   // op[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // next_location[15:0], out_byte[23:16], out_repeat[39:24]
  output logic [1:0]  out_tuser   // out_valid[0], bound_error[1]
);
  import tme_pkg::*;

  tape_wr_t wr;
  logic     rd_en;
  ptr_t     rd_addr;
  cell_t    rd_data;
  logic     clr_busy;
  logic     s1_v;
  issue_t   s1;
  logic     s1_go;
  result_t  res;

  tme_tape u_tape (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  tme_issue u_issue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .clr_busy  (clr_busy),
    .s1_go     (s1_go),
    .wr        (wr),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .s1_v      (s1_v),
    .s1        (s1)
  );

  tme_exec u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_v       (s1_v),
    .s1         (s1),
    .rd_data    (rd_data),
    .s1_go      (s1_go),
    .wr         (wr),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res        (res)
  );

  assign out_tdata = {res.repeat_o, res.byte_o, res.next_loc};
  assign out_tuser = {res.err, res.emit};

endmodule

`default_nettype wire

[src/tme_checker.sv]
// port-level checks for the tape machine instruction executor, bound to the top level
// depends only on the top level's ports
`default_nettype none

module tme_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // no result survives reset
  a_rst_no_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // tape clearing keeps the input closed on leaving reset
  a_clear_closed: assert property (@(posedge clk) $rose(rst_n) |-> !in_tready)
    else $error("input open while tape clear should be running");

  // an error result carries no characters
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |->
      !out_tuser[0] && out_tdata[39:24] == 16'd0 && out_tdata[23:16] == 8'd0)
    else $error("error result with output characters");

  // emitted characters always have a nonzero count
  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[39:24] != 16'd0)
    else $error("write result with zero repeat");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind tape_machine_instruction_executor_top tme_checker u_tme_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
